### src/assert_macros.svh
// Assertion macros shared by the ready queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define RQR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define RQR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Invariant checked on every clock edge outside reset.
`define RQR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`endif

### src/rqr_pkg.sv
// Types, constants and defaults for the ready queue.
`timescale 1ns / 1ps

package rqr_pkg;

    localparam int DEF_DEPTH     = 64;
    localparam int DEF_ID_BITS   = 16;
    localparam int ID_FIELD_BITS = 16;
    localparam int COUNT_BITS    = 7;

    typedef logic [1:0]               kind_t;
    typedef logic [ID_FIELD_BITS-1:0] id_field_t;
    typedef logic [COUNT_BITS-1:0]    count_t;

    localparam kind_t KIND_PUSH   = 2'd0;
    localparam kind_t KIND_POP    = 2'd1;
    localparam kind_t KIND_REMOVE = 2'd2;

    typedef struct packed {
        kind_t     kind;
        id_field_t thread_id;
    } cmd_t;

    typedef struct packed {
        id_field_t head_id;
        logic      head_valid;
        logic      found;
        logic      overflow;
        count_t    count;
    } result_t;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic cmp;
        logic push;
        logic pop;
        logic remove;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

### src/rqr_cell.sv
// One queue slot: holds an entry, compares it with the key, shifts toward the head.
`timescale 1ns / 1ps

module rqr_cell
    import rqr_pkg::*;
#(
    parameter int ID_BITS = DEF_ID_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctl_t          ctl,
    input  logic [ID_BITS-1:0] id,
    input  logic               left_valid,
    input  logic               kill_in,
    input  logic [ID_BITS-1:0] right_data,
    input  logic               right_valid,
    output logic [ID_BITS-1:0] data,
    output logic               valid,
    output logic               kill_out
);

    logic [ID_BITS-1:0] data_reg;
    logic [ID_BITS-1:0] data_next;
    logic               valid_reg;
    logic               valid_next;
    logic               match_reg;
    logic               match_next;
    logic               write_en;

    // Shift from here on once a deleted slot lies at or ahead of this cell.
    assign kill_out = kill_in | (ctl.remove & match_reg);
    assign write_en = ctl.push & ~valid_reg & left_valid;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        match_next = match_reg;
        if (ctl.cmp)
        begin
            match_next = valid_reg && (data_reg == id);
        end
        if (kill_out)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (write_en)
        begin
            data_next  = id;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
            data_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
            data_reg  <= data_next;
        end
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

### src/ready_queue_with_removal.sv
// done follows start via the EXEC state and the done register; a start is
// accepted only in IDLE. On acceptance every cell registers a key compare;
// EXEC runs the first-match prefix along the cell row and shifts, appends or
// deletes in one step. done is a one-cycle strobe; the receiver cannot stall.
// Reset clears every cell and the entry count; the queue is usable at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ready_queue_with_removal
    import rqr_pkg::*;
#(
    parameter int DEPTH   = DEF_DEPTH,
    parameter int ID_BITS = DEF_ID_BITS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t             state_reg;
    state_t             state_next;
    kind_t              kind_reg;
    kind_t              kind_next;
    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               done_reg;
    logic               done_next;
    result_t            result_reg;
    result_t            result_next;

    logic               accept;
    logic [ID_BITS-1:0] id_in;
    logic [ID_BITS-1:0] cell_id;
    cell_ctl_t          ctl;

    logic [ID_BITS-1:0] cell_data  [DEPTH];
    logic               cell_valid [DEPTH];
    logic               kill       [DEPTH+1];

    assign accept = start & (state_reg == ST_IDLE);
    assign id_in  = ID_BITS'(cmd.thread_id);
    assign busy   = (state_reg != ST_IDLE);

    always_comb
    begin
        ctl     = '0;
        cell_id = id_reg;
        if (accept)
        begin
            ctl.cmp = 1'b1;
            cell_id = id_in;
        end
        else if (state_reg == ST_EXEC)
        begin
            case (kind_reg)
                KIND_PUSH:   ctl.push   = 1'b1;
                KIND_POP:    ctl.pop    = 1'b1;
                KIND_REMOVE: ctl.remove = 1'b1;
                default:     ctl        = '0;
            endcase
        end
    end

    assign kill[0] = ctl.pop;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic               left_v;
        logic [ID_BITS-1:0] right_d;
        logic               right_v;

        if (i == 0)
        begin : g_first
            assign left_v = 1'b1;
        end
        else
        begin : g_inner_left
            assign left_v = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = '0;
            assign right_v = 1'b0;
        end
        else
        begin : g_inner_right
            assign right_d = cell_data[i+1];
            assign right_v = cell_valid[i+1];
        end

        rqr_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .id          (cell_id),
            .left_valid  (left_v),
            .kill_in     (kill[i]),
            .right_data  (right_d),
            .right_valid (right_v),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .kill_out    (kill[i+1])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        id_next     = id_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = cmd.kind;
                    id_next    = id_in;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                result_next = '0;
                case (kind_reg)
                    KIND_PUSH:
                    begin
                        if (cell_valid[DEPTH-1])
                        begin
                            result_next.overflow = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    KIND_POP:
                    begin
                        if (cell_valid[0])
                        begin
                            result_next.head_id    = id_field_t'(cell_data[0]);
                            result_next.head_valid = 1'b1;
                            count_next             = count_reg - CNT_W'(1);
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (kill[DEPTH])
                        begin
                            result_next.found = 1'b1;
                            count_next        = count_reg - CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
                result_next.count = count_t'(count_next);
                done_next         = 1'b1;
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        id_reg     <= id_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // An accepted start sets busy without done; done only follows busy.
    `RQR_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy && !done)
    `RQR_ASSERT_IMP(a_done_after_exec, clk, rst_n, done, !busy && $past(busy))
    `RQR_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `RQR_ASSERT_IMP(a_one_flag, clk, rst_n, done,
                    $countones({result.head_valid, result.found, result.overflow}) <= 1)

endmodule
